@@ rtl/cllq_pkg.sv @@
package cllq_pkg;

  // Command codes carried in the input item
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Field widths of the stream items
  localparam int ELEM_W = 4;
  localparam int SIZE_W = 5;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_QUEUED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

endpackage

@@ rtl/circular_linked_queue_manager.sv @@
// Circular doubly linked queue manager.
// Keeps one circular queue over a pool of CAPACITY element numbers (2..16).
// Input channel in_*: one item per command. in_tdata bit 0 is the command
// (0 append at tail, 1 remove) and bits 4:1 the element number.
// Result channel out_*: exactly one item per command, holding the status
// (done, already queued, queue empty, element not in queue), the queue
// size after the command and the head element (0 when the queue is empty).
// A command accepted into the input register moves on to the output
// register when free; one command per cycle while out_tready is high. Link
// tables are flip-flop arrays written in the same cycle that the result
// register loads, so the following command already sees the updated queue.
// Reset (rst_n low, synchronous) empties the queue: all membership flags,
// the count and the head clear; the link tables are not cleared.
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more command; in_tready then drops until
// the result is taken.
module circular_linked_queue_manager
  import cllq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] command, [4:1] element, [7:5] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [1:0] status, [6:2] size, [10:7] head_element, [15:11] zero
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Input register
  logic              in_vld_r;
  logic              cmd_r;
  logic [ELEM_W-1:0] elem_r;

  // Queue state
  logic [IDX_W-1:0]    next_r [CAPACITY];
  logic [IDX_W-1:0]    prev_r [CAPACITY];
  logic [CAPACITY-1:0] queued_r, queued_nxt;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [IDX_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  // Result register
  logic              out_vld_r;
  status_t           status_r, status_nxt;
  logic [SIZE_W-1:0] size_r;
  logic [ELEM_W-1:0] head_out_r;

  // Link table write ports
  logic             nx_we_a, nx_we_b, pv_we_a, pv_we_b;
  logic [IDX_W-1:0] nx_wa_a, nx_wa_b, pv_wa_a, pv_wa_b;
  logic [IDX_W-1:0] nx_wd_a, nx_wd_b, pv_wd_a, pv_wd_b;

  logic             adv;
  logic [IDX_W-1:0] e_idx, e_nx, e_pv;
  logic             in_pool, is_queued, q_empty;

  // Move the held command to the result side when the output is free
  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  assign e_idx     = IDX_W'(elem_r);
  assign in_pool   = int'(elem_r) < CAPACITY;
  assign is_queued = in_pool && queued_r[e_idx];
  assign q_empty   = (cnt_r == '0);
  assign e_nx      = next_r[e_idx];
  assign e_pv      = prev_r[e_idx];

  // Decode the command into state updates and link writes
  always_comb begin
    queued_nxt = queued_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    status_nxt = ST_DONE;
    nx_we_a = 1'b0; nx_wa_a = e_idx; nx_wd_a = e_idx;
    nx_we_b = 1'b0; nx_wa_b = tail_r; nx_wd_b = e_idx;
    pv_we_a = 1'b0; pv_wa_a = e_idx; pv_wd_a = e_idx;
    pv_we_b = 1'b0; pv_wa_b = head_r; pv_wd_b = e_idx;
    if (cmd_r == CMD_APPEND) begin
      if (!in_pool) begin
        status_nxt = ST_ABSENT;
      end else if (is_queued) begin
        status_nxt = ST_QUEUED;
      end else begin
        // Link in just before the head
        queued_nxt[e_idx] = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        tail_nxt = e_idx;
        nx_we_a  = 1'b1;
        pv_we_a  = 1'b1;
        if (q_empty) begin
          head_nxt = e_idx;
        end else begin
          nx_wd_a = head_r;
          pv_wd_a = tail_r;
          nx_we_b = 1'b1;
          pv_we_b = 1'b1;
        end
      end
    end else begin
      if (q_empty) begin
        status_nxt = ST_EMPTY;
      end else if (!is_queued) begin
        status_nxt = ST_ABSENT;
      end else begin
        queued_nxt[e_idx] = 1'b0;
        cnt_nxt = cnt_r - 1'b1;
        if (e_nx == e_idx) begin
          // Last element leaves: queue empties
          head_nxt = '0;
          tail_nxt = '0;
        end else begin
          if (head_r == e_idx) head_nxt = e_nx;
          if (tail_r == e_idx) tail_nxt = e_pv;
          // Bridge the neighbors around the removed element
          nx_we_a = 1'b1; nx_wa_a = e_pv; nx_wd_a = e_nx;
          pv_we_a = 1'b1; pv_wa_a = e_nx; pv_wd_a = e_pv;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      queued_r  <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      cnt_r     <= '0;
    end else begin
      if (in_tready) in_vld_r <= in_tvalid;
      if (adv) begin
        out_vld_r <= 1'b1;
        queued_r  <= queued_nxt;
        head_r    <= head_nxt;
        tail_r    <= tail_nxt;
        cnt_r     <= cnt_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r  <= in_tdata[0];
      elem_r <= in_tdata[4:1];
    end
    if (adv) begin
      status_r   <= status_nxt;
      size_r     <= SIZE_W'(cnt_nxt);
      head_out_r <= ELEM_W'(head_nxt);
    end
  end

  // Link tables
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (adv && nx_we_a && nx_wa_a == IDX_W'(i)) next_r[i] <= nx_wd_a;
      if (adv && nx_we_b && nx_wa_b == IDX_W'(i)) next_r[i] <= nx_wd_b;
      if (adv && pv_we_a && pv_wa_a == IDX_W'(i)) prev_r[i] <= pv_wd_a;
      if (adv && pv_we_b && pv_wa_b == IDX_W'(i)) prev_r[i] <= pv_wd_b;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, head_out_r, size_r, status_r};

  // Membership flags and count agree
  a_count_flags: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(queued_r) == int'(cnt_r))
    else $error("queue count does not match membership flags");

  // Head and tail are members of a non-empty queue
  a_head_tail_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (queued_r[head_r] && queued_r[tail_r]))
    else $error("head or tail not queued");

  // Empty queue parks head at zero
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (head_r == '0))
    else $error("empty queue with nonzero head");

  // A state change only happens together with a result load
  a_count_moves_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(adv) |-> $stable(cnt_r))
    else $error("count changed without a command");

endmodule

@@ tb/sv/tb_circular_linked_queue_manager.sv @@
module tb_circular_linked_queue_manager
  import cllq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL        = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int BLOCKS      = 30;
  localparam int BLOCK_ITEMS = 30;

  // Random block kinds: mostly appends, mostly removes, or an even mix
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  typedef struct {
    status_t    status;
    logic [4:0] size;
    logic [3:0] head;
  } reply_t;

  // Queue scoreboard: tracks the linked queue and the replies still owed
  class queue_scoreboard;
    logic [3:0]  next_of [POOL];
    logic [3:0]  prev_of [POOL];
    bit          member  [POOL];
    logic [3:0]  head_idx;
    int unsigned depth;
    reply_t      owed_replies[$];
    int          errors;
    int          status_seen [4];
    int          peak_depth;
    int          appends;
    int          removes;

    function new();
      foreach (member[i]) member[i] = 1'b0;
      head_idx   = '0;
      depth      = 0;
      errors     = 0;
      peak_depth = 0;
      appends    = 0;
      removes    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Link an element in just before the head
    function status_t link_at_tail(logic [3:0] e);
      logic [3:0] tail;
      if (member[e]) return ST_QUEUED;
      if (depth == 0) begin
        next_of[e] = e;
        prev_of[e] = e;
        head_idx   = e;
      end else begin
        tail              = prev_of[head_idx];
        next_of[tail]     = e;
        prev_of[e]        = tail;
        prev_of[head_idx] = e;
        next_of[e]        = head_idx;
      end
      member[e] = 1'b1;
      depth++;
      return ST_DONE;
    endfunction

    // Unlink an element, moving the head on when it leaves
    function status_t unlink(logic [3:0] e);
      logic [3:0] nx;
      logic [3:0] pv;
      if (depth == 0) return ST_EMPTY;
      if (!member[e]) return ST_ABSENT;
      nx = next_of[e];
      pv = prev_of[e];
      if (nx == e) begin
        head_idx = '0;
      end else begin
        if (head_idx == e) head_idx = nx;
        next_of[pv] = nx;
        prev_of[nx] = pv;
      end
      member[e] = 1'b0;
      depth--;
      return ST_DONE;
    endfunction

    // Note an accepted command and queue the reply it owes
    function void note_command(logic cmd, logic [3:0] e);
      reply_t r;
      if (cmd == CMD_APPEND) begin
        r.status = link_at_tail(e);
        appends++;
      end else begin
        r.status = unlink(e);
        removes++;
      end
      r.size = depth[4:0];
      r.head = (depth != 0) ? head_idx : 4'd0;
      if (depth > peak_depth) peak_depth = depth;
      status_seen[r.status]++;
      owed_replies.push_back(r);
    endfunction

    // Compare a taken reply with the oldest one owed
    function void check_result(logic [15:0] data);
      reply_t want;
      if (owed_replies.size() == 0) begin
        $display("%0t: unexpected reply 0x%04h", $time, data);
        errors++;
        return;
      end
      want = owed_replies.pop_front();
      if (data[1:0] !== want.status) begin
        $display("%0t: status mismatch expected %0d actual %0d",
                 $time, want.status, data[1:0]);
        errors++;
      end
      if (data[6:2] !== want.size) begin
        $display("%0t: size mismatch expected %0d actual %0d",
                 $time, want.size, data[6:2]);
        errors++;
      end
      if (data[10:7] !== want.head) begin
        $display("%0t: head_element mismatch expected %0d actual %0d",
                 $time, want.head, data[10:7]);
        errors++;
      end
    endfunction

    function int pending();
      return owed_replies.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  queue_scoreboard sb = new();
  bit              calm = 1'b0;
  int              cycles = 0;

  always #6 clk = ~clk;

  circular_linked_queue_manager DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one command, hold it until taken, then note it
  task automatic send_command(logic cmd, logic [3:0] e);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, e, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, e);
    @(negedge clk);
  endtask

  // Take replies with a random stall before each one
  task automatic take_replies();
    int stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
      @(negedge clk);
    end
  endtask

  // Pick an element that mostly hits a live case for the command
  function automatic logic [3:0] pick_element(logic cmd);
    logic [3:0] cand[$];
    for (int i = 0; i < POOL; i++) begin
      if (sb.member[i] == (cmd == CMD_REMOVE)) cand.push_back(4'(i));
    end
    if (cand.size() != 0 && $urandom_range(0, 9) < 8)
      return cand[$urandom_range(0, cand.size() - 1)];
    return 4'($urandom_range(0, POOL - 1));
  endfunction

  // Drop the offer and hold off until every owed reply is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Send a block of random commands with the given append share
  task automatic random_block(mix_t mix);
    int   append_pct;
    logic cmd;
    case (mix)
      MIX_FILL:  append_pct = 85;
      MIX_DRAIN: append_pct = 15;
      default:   append_pct = 50;
    endcase
    repeat (BLOCK_ITEMS) begin
      cmd = ($urandom_range(0, 99) < append_pct) ? CMD_APPEND : CMD_REMOVE;
      send_command(cmd, pick_element(cmd));
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    fork
      take_replies();
    join_none

    // Empty-queue removes, duplicate append, absent remove, last removal
    send_command(CMD_REMOVE, 4'd3);
    send_command(CMD_REMOVE, 4'd12);
    send_command(CMD_APPEND, 4'd0);
    send_command(CMD_APPEND, 4'd0);
    send_command(CMD_REMOVE, 4'd9);
    send_command(CMD_REMOVE, 4'd0);
    // Head, tail and middle removal over extreme element numbers
    send_command(CMD_APPEND, 4'd15);
    send_command(CMD_APPEND, 4'd0);
    send_command(CMD_APPEND, 4'd7);
    send_command(CMD_APPEND, 4'd8);
    send_command(CMD_APPEND, 4'd15);
    send_command(CMD_REMOVE, 4'd15);
    send_command(CMD_REMOVE, 4'd8);
    send_command(CMD_REMOVE, 4'd4);
    send_command(CMD_REMOVE, 4'd0);
    send_command(CMD_REMOVE, 4'd7);
    send_command(CMD_APPEND, 4'd5);
    send_command(CMD_APPEND, 4'd10);
    send_command(CMD_APPEND, 4'd3);
    send_command(CMD_REMOVE, 4'd10);
    send_command(CMD_REMOVE, 4'd3);
    send_command(CMD_REMOVE, 4'd5);

    // Hold off until every reply is back
    wait_drained();

    for (int b = 0; b < BLOCKS; b++) begin
      calm = ($urandom_range(0, 3) == 0);
      random_block(mix_t'($urandom_range(0, 2)));
      if (b == BLOCKS / 2) wait_drained();
    end
    calm = 1'b0;

    wait_drained();
    repeat (10) @(negedge clk);

    $display("Ran %0d appends and %0d removes, peak queue depth %0d of %0d.",
             sb.appends, sb.removes, sb.peak_depth, POOL);
    $display("Replies by status: done %0d, already queued %0d, empty %0d, absent %0d.",
             sb.status_seen[ST_DONE], sb.status_seen[ST_QUEUED],
             sb.status_seen[ST_EMPTY], sb.status_seen[ST_ABSENT]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cllq_pkg.sv
rtl/circular_linked_queue_manager.sv
tb/sv/tb_circular_linked_queue_manager.sv
